// ----- rtl/ipv4hc_pkg.sv -----
// Shared types and constants for the IPv4 receive header checker.
package ipv4hc_pkg;

    localparam logic [5:0] MIN_HDR = 6'd20;
    localparam logic [7:0] OPT_TIMESTAMP = 8'd68;
    localparam logic [7:0] OPT_TS_MIN_LEN = 8'd12;
    localparam logic [0:0] REG_CHECKSUM_SOURCE = 1'b0;
    localparam logic [0:0] REG_STRICT_CHECKS = 1'b1;

    localparam logic [2:0] VERDICT_ACCEPT = 3'd0;
    localparam logic [2:0] VERDICT_SHORT = 3'd1;
    localparam logic [2:0] VERDICT_FRAGMENT = 3'd2;
    localparam logic [2:0] VERDICT_HDR_SMALL = 3'd3;
    localparam logic [2:0] VERDICT_TOTAL_LEN = 3'd4;
    localparam logic [2:0] VERDICT_NOT_V4 = 3'd5;
    localparam logic [2:0] VERDICT_BAD_OPTION = 3'd6;
    localparam logic [2:0] VERDICT_BAD_CSUM = 3'd7;

    localparam int QUEUE_DEPTH = 2;

    // Everything the front hands the back at the end of one packet.
    typedef struct packed {
        logic [15:0] length;
        logic [7:0]  version_and_ihl;
        logic [15:0] length_field;
        logic [15:0] flags_offset_word;
        logic [7:0]  protocol_field;
        logic [15:0] checksum_sum;
        logic        option_error;
        logic        timestamp_seen;
        logic [63:0] timestamp_value;
        logic        external_checksum_bad;
        logic        checksum_source;
        logic        strict_checks;
    } packet_summary_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic        counted;
        logic [7:0]  protocol_number;
        logic [1:0]  protocol_class;
        logic [5:0]  header_length;
        logic [15:0] ip_total_length;
        logic [15:0] payload_length;
        logic        reserved_bit_set;
        logic        timestamp_found;
        logic [63:0] timestamp_value;
    } verdict_beat_t;

endpackage

// ----- rtl/ipv4hc_front.sv -----
// Byte parser: captures header fields, sums the header and walks options.
module ipv4hc_front
    import ipv4hc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            beat_valid,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    input  logic            external_checksum_bad,
    input  logic            checksum_source,
    input  logic            strict_checks,
    output logic            summary_valid,
    output packet_summary_t summary
);

    logic [15:0] pos_reg;
    logic [7:0]  vihl_reg;
    logic [15:0] len_reg;
    logic [15:0] flags_reg;
    logic [7:0]  proto_reg;
    logic [16:0] sum_reg;
    logic [7:0]  high_reg;
    logic [5:0]  opt_start_reg;
    logic [7:0]  opt_code_reg;
    logic [7:0]  opt_len_reg;
    logic        opt_err_reg;
    logic [63:0] ts_reg;
    logic        ts_seen_reg;

    logic [7:0]  vihl_next;
    logic [15:0] len_next;
    logic [15:0] flags_next;
    logic [7:0]  proto_next;
    logic [16:0] sum_next;
    logic [7:0]  high_next;
    logic [5:0]  opt_start_next;
    logic [7:0]  opt_code_next;
    logic [7:0]  opt_len_next;
    logic        opt_err_next;
    logic [63:0] ts_next;
    logic        ts_seen_next;
    logic [15:0] pos_next;

    logic [5:0]  hl;
    logic        in_hdr;
    logic [16:0] add;
    logic [15:0] rem_start;
    logic [15:0] rem_pos;
    logic [15:0] d;
    logic [2:0]  k;
    logic [5:0]  sh;

    always_comb
    begin
        vihl_next = vihl_reg;
        len_next = len_reg;
        flags_next = flags_reg;
        proto_next = proto_reg;
        unique case (pos_reg)
            16'd0: vihl_next = data_byte;
            16'd2: len_next = {data_byte, len_reg[7:0]};
            16'd3: len_next = {len_reg[15:8], data_byte};
            16'd6: flags_next = {data_byte, flags_reg[7:0]};
            16'd7: flags_next = {flags_reg[15:8], data_byte};
            16'd9: proto_next = data_byte;
            default: ;
        endcase
        hl = {vihl_next[3:0], 2'b00};
        in_hdr = pos_reg < {10'd0, hl};

        sum_next = sum_reg;
        high_next = high_reg;
        add = sum_reg + {1'b0, high_reg, data_byte};
        if (in_hdr)
        begin
            if (!pos_reg[0])
                high_next = data_byte;
            else
                sum_next = {1'b0, add[15:0]} + {16'd0, add[16]};
        end

        opt_start_next = opt_start_reg;
        opt_code_next = opt_code_reg;
        opt_len_next = opt_len_reg;
        opt_err_next = opt_err_reg;
        ts_next = ts_reg;
        ts_seen_next = ts_seen_reg;
        rem_pos = {10'd0, hl} - pos_reg;
        rem_start = {10'd0, hl} - {10'd0, opt_start_reg};
        d = pos_reg - ({10'd0, opt_start_reg} - {8'd0, opt_len_reg});
        k = d[2:0] - 3'd4;
        sh = k[2] ? {1'b1, ~k[1:0], 3'b000} : {1'b0, ~k[1:0], 3'b000};
        if (pos_reg >= {10'd0, MIN_HDR} && in_hdr && !opt_err_reg)
        begin
            if (pos_reg == {10'd0, opt_start_reg})
            begin
                if (rem_pos < 16'd4)
                    opt_err_next = 1'b1;
                else
                    opt_code_next = data_byte;
            end
            else if (pos_reg == {10'd0, opt_start_reg} + 16'd1)
            begin
                if (data_byte == 8'd0 || {8'd0, data_byte} > rem_start
                    || (opt_code_reg == OPT_TIMESTAMP && data_byte < OPT_TS_MIN_LEN))
                    opt_err_next = 1'b1;
                else
                begin
                    opt_len_next = data_byte;
                    opt_start_next = opt_start_reg + data_byte[5:0];
                    if (data_byte == 8'd1)
                    begin
                        if (rem_pos < 16'd4)
                            opt_err_next = 1'b1;
                        else
                            opt_code_next = data_byte;
                    end
                end
            end
            else if (pos_reg < {10'd0, opt_start_reg} && opt_code_reg == OPT_TIMESTAMP)
            begin
                if (d >= 16'd4 && d <= 16'd11)
                begin
                    ts_next = (ts_reg & ~(64'hFF << sh)) | ({56'd0, data_byte} << sh);
                    if (k == 3'd7)
                        ts_seen_next = 1'b1;
                end
            end
        end
        pos_next = (pos_reg != 16'hFFFF) ? pos_reg + 16'd1 : pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            vihl_reg <= '0;
            len_reg <= '0;
            flags_reg <= '0;
            proto_reg <= '0;
            sum_reg <= '0;
            high_reg <= '0;
            opt_start_reg <= MIN_HDR;
            opt_code_reg <= '0;
            opt_len_reg <= '0;
            opt_err_reg <= 1'b0;
            ts_reg <= '0;
            ts_seen_reg <= 1'b0;
            summary_valid <= 1'b0;
        end
        else
        begin
            summary_valid <= beat_valid && last_byte;
            if (beat_valid)
            begin
                if (last_byte)
                begin
                    pos_reg <= '0;
                    vihl_reg <= '0;
                    len_reg <= '0;
                    flags_reg <= '0;
                    proto_reg <= '0;
                    sum_reg <= '0;
                    high_reg <= '0;
                    opt_start_reg <= MIN_HDR;
                    opt_code_reg <= '0;
                    opt_len_reg <= '0;
                    opt_err_reg <= 1'b0;
                    ts_reg <= '0;
                    ts_seen_reg <= 1'b0;
                end
                else
                begin
                    pos_reg <= pos_next;
                    vihl_reg <= vihl_next;
                    len_reg <= len_next;
                    flags_reg <= flags_next;
                    proto_reg <= proto_next;
                    sum_reg <= sum_next;
                    high_reg <= high_next;
                    opt_start_reg <= opt_start_next;
                    opt_code_reg <= opt_code_next;
                    opt_len_reg <= opt_len_next;
                    opt_err_reg <= opt_err_next;
                    ts_reg <= ts_next;
                    ts_seen_reg <= ts_seen_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_valid && last_byte)
        begin
            summary.length <= pos_next;
            summary.version_and_ihl <= vihl_next;
            summary.length_field <= len_next;
            summary.flags_offset_word <= flags_next;
            summary.protocol_field <= proto_next;
            summary.checksum_sum <= sum_next[15:0];
            summary.option_error <= opt_err_next;
            summary.timestamp_seen <= ts_seen_next;
            summary.timestamp_value <= ts_next;
            summary.external_checksum_bad <= external_checksum_bad;
            summary.checksum_source <= checksum_source;
            summary.strict_checks <= strict_checks;
        end
    end

endmodule

// ----- rtl/ipv4hc_queue.sv -----
// Small result queue between the verdict stage and the output interface.
module ipv4hc_queue
    import ipv4hc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  verdict_beat_t wr_data,
    input  logic          rd_en,
    output logic          empty,
    output logic          full,
    output verdict_beat_t rd_data
);

    verdict_beat_t mem [QUEUE_DEPTH];
    logic [0:0] wr_ptr_reg;
    logic [0:0] rd_ptr_reg;
    logic [1:0] count_reg;

    assign empty = (count_reg == 2'd0);
    assign full = (count_reg == 2'd2);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

endmodule

// ----- rtl/ipv4hc_back.sv -----
// Verdict stage: runs the ordered checks on a finished packet summary.
module ipv4hc_back
    import ipv4hc_pkg::*;
(
    input  packet_summary_t summary,
    output verdict_beat_t   beat
);

    logic [5:0]  hl;
    logic [2:0]  verdict;
    logic        counted;
    logic        reached;
    logic        csum_bad;
    packet_summary_t s;

    always_comb
    begin
        s = summary;
        hl = {s.version_and_ihl[3:0], 2'b00};
        csum_bad = s.checksum_source ? s.external_checksum_bad
                                     : (s.checksum_sum != 16'hFFFF);
        counted = 1'b0;
        if (s.flags_offset_word[13] || s.flags_offset_word[12:0] != 13'd0)
            verdict = VERDICT_FRAGMENT;
        else
        begin
            counted = 1'b1;
            if (s.length < {10'd0, hl})
                verdict = VERDICT_SHORT;
            else if (hl < MIN_HDR)
                verdict = VERDICT_HDR_SMALL;
            else if (s.length_field < {10'd0, hl} || s.length_field > s.length)
                verdict = VERDICT_TOTAL_LEN;
            else if (s.strict_checks && s.version_and_ihl[7:4] != 4'd4)
                verdict = VERDICT_NOT_V4;
            else if (s.option_error)
                verdict = VERDICT_BAD_OPTION;
            else if (csum_bad)
                verdict = VERDICT_BAD_CSUM;
            else
                verdict = VERDICT_ACCEPT;
        end
        reached = (verdict == VERDICT_ACCEPT) || (verdict == VERDICT_BAD_OPTION)
                  || (verdict == VERDICT_BAD_CSUM);

        beat = '0;
        if (s.length < {10'd0, MIN_HDR})
            beat.verdict = VERDICT_SHORT;
        else
        begin
            beat.verdict = verdict;
            beat.counted = counted;
            beat.protocol_number = s.protocol_field;
            case (s.protocol_field)
                8'd6: beat.protocol_class = 2'd0;
                8'd17: beat.protocol_class = 2'd1;
                8'd1: beat.protocol_class = 2'd2;
                default: beat.protocol_class = 2'd3;
            endcase
            beat.header_length = hl;
            beat.ip_total_length = s.length_field;
            beat.payload_length = (verdict == VERDICT_ACCEPT)
                                  ? s.length_field - {10'd0, hl} : 16'd0;
            beat.reserved_bit_set = reached && s.strict_checks && s.flags_offset_word[15];
            beat.timestamp_found = reached && s.timestamp_seen;
            beat.timestamp_value = (reached && s.timestamp_seen) ? s.timestamp_value : 64'd0;
        end
    end

endmodule

// ----- rtl/ipv4_receive_header_checker_core.sv -----
// Top level of the IPv4 receive header checker.
//
// Usage: packet bytes enter as beats on the input queue interface (push,
// full), one byte per beat starting at the first IPv4 header byte, with
// last_byte high on the final beat. One verdict beat per packet appears
// on the output queue interface (empty, pop) and stays until popped.
// The parser takes one byte per cycle while full is low, with no gaps
// between packets. The last byte of a packet is registered as a summary,
// judged in the next cycle and written into a two-entry result queue,
// whose head drives the verdict outputs. When the receiver stalls,
// the queue fills; full rises once the queue and the summary stage could
// not take another verdict, and pushes are held off until pop frees room.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect on
// the next cycle and are meant only while the block is idle.
// Reset clears the parser to the start of a packet, empties the queue
// and sets checksum_source and strict_checks to 1.
module ipv4_receive_header_checker_core
    import ipv4hc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        external_checksum_bad,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  verdict,
    output logic        counted,
    output logic [7:0]  protocol_number,
    output logic [1:0]  protocol_class,
    output logic [5:0]  header_length,
    output logic [15:0] ip_total_length,
    output logic [15:0] payload_length,
    output logic        reserved_bit_set,
    output logic        timestamp_found,
    output logic [63:0] timestamp_value,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic        cfg_data
);

    logic            checksum_source_reg;
    logic            strict_checks_reg;
    logic            accept;
    logic            summary_valid;
    packet_summary_t summary;
    verdict_beat_t   judged;
    verdict_beat_t   head;
    logic            q_empty;
    logic            q_full;
    logic            q_pop;

    // Stall pushes while the queue is full, or while a summary is in flight and
    // the queue has no room left behind it; a single free slot covers the in-flight one.
    assign full = q_full || (summary_valid && !q_empty && !q_pop);
    assign accept = push && !full;
    assign empty = q_empty;
    assign q_pop = pop && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            checksum_source_reg <= 1'b1;
            strict_checks_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_CHECKSUM_SOURCE)
                checksum_source_reg <= cfg_data;
            else if (cfg_index == REG_STRICT_CHECKS)
                strict_checks_reg <= cfg_data;
        end
    end

    ipv4hc_front u_front (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .beat_valid            (accept),
        .data_byte             (data_byte),
        .last_byte             (last_byte),
        .external_checksum_bad (external_checksum_bad),
        .checksum_source       (checksum_source_reg),
        .strict_checks         (strict_checks_reg),
        .summary_valid         (summary_valid),
        .summary               (summary)
    );

    ipv4hc_back u_back (
        .summary (summary),
        .beat    (judged)
    );

    ipv4hc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (summary_valid),
        .wr_data (judged),
        .rd_en   (q_pop),
        .empty   (q_empty),
        .full    (q_full),
        .rd_data (head)
    );

    assign verdict = head.verdict;
    assign counted = head.counted;
    assign protocol_number = head.protocol_number;
    assign protocol_class = head.protocol_class;
    assign header_length = head.header_length;
    assign ip_total_length = head.ip_total_length;
    assign payload_length = head.payload_length;
    assign reserved_bit_set = head.reserved_bit_set;
    assign timestamp_found = head.timestamp_found;
    assign timestamp_value = head.timestamp_value;

endmodule

// ----- verif/ipv4hc_checker.sv -----
// Watches the IPv4 header checker channels, predicts each verdict beat and compares it.
module ipv4hc_checker
    import ipv4hc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        external_checksum_bad,
    input  logic        empty,
    input  logic        pop,
    input  logic [2:0]  verdict,
    input  logic        counted,
    input  logic [7:0]  protocol_number,
    input  logic [1:0]  protocol_class,
    input  logic [5:0]  header_length,
    input  logic [15:0] ip_total_length,
    input  logic [15:0] payload_length,
    input  logic        reserved_bit_set,
    input  logic        timestamp_found,
    input  logic [63:0] timestamp_value,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic        cfg_data,
    output int          fail_count,
    output int          pending_verdicts
);

    logic        csum_src_q, strict_q;
    logic [15:0] pos_q;
    logic [7:0]  vihl_q;
    logic [15:0] tlen_q, flags_q;
    logic [7:0]  proto_q;
    logic [16:0] sum_q;
    logic [7:0]  hi_q;
    logic [5:0]  opt_start_q;
    logic [7:0]  opt_code_q, opt_len_q;
    logic        opt_err_q;
    logic [63:0] ts_q;
    logic        ts_seen_q;

    verdict_beat_t expected_verdicts[$];

    task automatic clear_packet();
        pos_q = '0; vihl_q = '0; tlen_q = '0; flags_q = '0; proto_q = '0;
        sum_q = '0; hi_q = '0; opt_start_q = MIN_HDR; opt_code_q = '0;
        opt_len_q = '0; opt_err_q = 1'b0; ts_q = '0; ts_seen_q = 1'b0;
    endtask

    task automatic open_option(int p, logic [7:0] b, int hl);
        if (hl - p < 4) opt_err_q = 1'b1;
        else opt_code_q = b;
    endtask

    task automatic walk_option(int p, logic [7:0] b, int hl);
        int st, d, k, sh;
        st = opt_start_q;
        if (p == st) begin
            open_option(p, b, hl);
        end else if (p == st + 1) begin
            if (b == 0 || b > hl - st || (opt_code_q == OPT_TIMESTAMP && b < OPT_TS_MIN_LEN))
            begin
                opt_err_q = 1'b1;
            end else begin
                opt_len_q = b;
                opt_start_q = 6'((st + b) & 6'h3f);
                if (b == 1) open_option(p, b, hl);
            end
        end else if (p < st && opt_code_q == OPT_TIMESTAMP) begin
            d = p - (st - opt_len_q);
            if (d >= 4 && d <= 11) begin
                k = d - 4;
                sh = (k < 4) ? (3 - k) * 8 : 32 + (7 - k) * 8;
                ts_q = (ts_q & ~(64'hff << sh)) | (64'(b) << sh);
                if (k == 7) ts_seen_q = 1'b1;
            end
        end
    endtask

    task automatic take_byte(logic [7:0] b, logic last, logic ext);
        int p, hl, len;
        verdict_beat_t e;
        logic reached;
        p = pos_q;
        case (p)
            0: vihl_q = b;
            2: tlen_q[15:8] = b;
            3: tlen_q[7:0] = b;
            6: flags_q[15:8] = b;
            7: flags_q[7:0] = b;
            9: proto_q = b;
            default: ;
        endcase
        hl = vihl_q[3:0] * 4;
        if (p < hl) begin
            if (p[0] == 1'b0) hi_q = b;
            else begin
                sum_q = sum_q + {hi_q, b};
                sum_q = {1'b0, sum_q[15:0]} + sum_q[16];
            end
        end
        if (p >= MIN_HDR && p < hl && !opt_err_q) walk_option(p, b, hl);
        pos_q = (pos_q != 16'hffff) ? pos_q + 1 : pos_q;
        if (!last) return;
        e = '0;
        len = pos_q;
        if (len < MIN_HDR) begin
            e.verdict = VERDICT_SHORT;
        end else begin
            if (flags_q[13] || flags_q[12:0] != 0) e.verdict = VERDICT_FRAGMENT;
            else begin
                e.counted = 1'b1;
                if (len < hl) e.verdict = VERDICT_SHORT;
                else if (hl < MIN_HDR) e.verdict = VERDICT_HDR_SMALL;
                else if (tlen_q < hl || tlen_q > len) e.verdict = VERDICT_TOTAL_LEN;
                else if (strict_q && vihl_q[7:4] != 4'h4) e.verdict = VERDICT_NOT_V4;
                else if (opt_err_q) e.verdict = VERDICT_BAD_OPTION;
                else if (csum_src_q ? ext : (sum_q != 17'hffff)) e.verdict = VERDICT_BAD_CSUM;
                else e.verdict = VERDICT_ACCEPT;
            end
            e.protocol_number = proto_q;
            e.protocol_class = (proto_q == 6) ? 2'd0 : (proto_q == 17) ? 2'd1 :
                               (proto_q == 1) ? 2'd2 : 2'd3;
            e.header_length = 6'(hl);
            e.ip_total_length = tlen_q;
            e.payload_length = (e.verdict == VERDICT_ACCEPT) ? 16'(tlen_q - hl) : 16'd0;
            reached = e.verdict inside {VERDICT_ACCEPT, VERDICT_BAD_OPTION, VERDICT_BAD_CSUM};
            e.reserved_bit_set = reached && strict_q && flags_q[15];
            e.timestamp_found = reached && ts_seen_q;
            e.timestamp_value = (reached && ts_seen_q) ? ts_q : 64'd0;
        end
        expected_verdicts.push_back(e);
        clear_packet();
    endtask

    task automatic compare_beat();
        verdict_beat_t e;
        if (expected_verdicts.size() == 0) begin
            $error("verdict beat with nothing expected");
            fail_count++;
            return;
        end
        e = expected_verdicts.pop_front();
        if (verdict !== e.verdict) begin
            $error("verdict exp %0d got %0d", e.verdict, verdict); fail_count++;
        end
        if (counted !== e.counted) begin
            $error("counted exp %0d got %0d", e.counted, counted); fail_count++;
        end
        if (protocol_number !== e.protocol_number) begin
            $error("protocol_number exp %0d got %0d", e.protocol_number, protocol_number);
            fail_count++;
        end
        if (protocol_class !== e.protocol_class) begin
            $error("protocol_class exp %0d got %0d", e.protocol_class, protocol_class);
            fail_count++;
        end
        if (header_length !== e.header_length) begin
            $error("header_length exp %0d got %0d", e.header_length, header_length);
            fail_count++;
        end
        if (ip_total_length !== e.ip_total_length) begin
            $error("ip_total_length exp %0d got %0d", e.ip_total_length, ip_total_length);
            fail_count++;
        end
        if (payload_length !== e.payload_length) begin
            $error("payload_length exp %0d got %0d", e.payload_length, payload_length);
            fail_count++;
        end
        if (reserved_bit_set !== e.reserved_bit_set) begin
            $error("reserved_bit_set exp %0d got %0d", e.reserved_bit_set, reserved_bit_set);
            fail_count++;
        end
        if (timestamp_found !== e.timestamp_found) begin
            $error("timestamp_found exp %0d got %0d", e.timestamp_found, timestamp_found);
            fail_count++;
        end
        if (timestamp_value !== e.timestamp_value) begin
            $error("timestamp_value exp %h got %h", e.timestamp_value, timestamp_value);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        pending_verdicts = 0;
        csum_src_q = 1'b1;
        strict_q = 1'b1;
        clear_packet();
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (pop && !empty) compare_beat();
            if (push && !full) take_byte(data_byte, last_byte, external_checksum_bad);
            if (cfg_write) begin
                if (cfg_index == REG_CHECKSUM_SOURCE) csum_src_q = cfg_data;
                else strict_q = cfg_data;
            end
        end
        pending_verdicts = expected_verdicts.size();
    end

endmodule

// ----- verif/tb_ipv4_receive_header_checker_core.sv -----
// Stimulus and verdict for the IPv4 receive header checker testbench.
module tb_ipv4_receive_header_checker_core;
    import ipv4hc_pkg::*;

    logic        clk, rst_n;
    logic        push, full, last_byte, external_checksum_bad, empty, pop;
    logic [7:0]  data_byte;
    logic [2:0]  verdict;
    logic        counted, reserved_bit_set, timestamp_found;
    logic [7:0]  protocol_number;
    logic [1:0]  protocol_class;
    logic [5:0]  header_length;
    logic [15:0] ip_total_length, payload_length;
    logic [63:0] timestamp_value;
    logic        cfg_write, cfg_index, cfg_data;
    int          fail_count, pending_verdicts;
    int          idle_cycles;
    // When set, both sides stop idling for a stretch of the run.
    bit          no_idle;
    // The receiver's stall chance in percent; 22 in normal running.
    int          pop_idle_pct;

    ipv4_receive_header_checker_core uut (.*);
    ipv4hc_checker chk (.*);

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver: pops at random on falling edges.
    always @(negedge clk) begin
        pop <= no_idle ? 1'b1 : ($urandom_range(99) >= pop_idle_pct);
    end

    // Watchdog: counts cycles with no accepted beat on either side.
    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("tb_ipv4_receive_header_checker_core NOT OK");
            $finish;
        end
    end

    // Hands one byte to the block, holding it until it is accepted. The
    // sender gaps at random before the beat unless idling is switched off.
    // Push stays high after the beat; the next beat or drain() replaces it.
    task automatic send_byte(logic [7:0] b, logic last, logic ext);
        while (!no_idle && $urandom_range(99) < 22) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        external_checksum_bad <= ext;
        @(posedge clk);
        while (full) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_packet(logic [7:0] pkt[$], logic ext);
        foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1, ext);
    endtask

    // Drops push and waits until every verdict has been popped, then idles
    // before returning.
    task automatic drain();
        int guard;
        guard = 0;
        push <= 1'b0;
        while (pending_verdicts != 0 && guard < 20000) begin
            @(negedge clk);
            guard++;
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Builds a header with the given IHL and options, fills the checksum so
    // that the sum comes out right unless good_sum is clear, then appends
    // payload bytes. The flags word and version may be bent to reach their checks.
    function automatic void build_packet(ref logic [7:0] pkt[$], input int ihl,
                                         input int payload, input bit good_sum,
                                         input bit frag, input bit good_ver,
                                         input bit options_ts);
        int hl, tl, s, i, olen;
        logic [15:0] csum;
        hl = ihl * 4;
        tl = hl + payload;
        pkt.delete();
        pkt.push_back({good_ver ? 4'h4 : 4'($urandom_range(15)), 4'(ihl)});
        pkt.push_back(8'($urandom));
        pkt.push_back(8'(tl >> 8));
        pkt.push_back(8'(tl));
        pkt.push_back(8'($urandom));
        pkt.push_back(8'($urandom));
        if (frag) pkt.push_back({1'($urandom_range(1)), 2'($urandom_range(1, 3)), 5'($urandom)});
        else pkt.push_back({1'($urandom), 7'd0});
        pkt.push_back(frag ? 8'($urandom) : 8'd0);
        pkt.push_back(8'($urandom));
        case ($urandom_range(3))
            0: pkt.push_back(8'd6);
            1: pkt.push_back(8'd17);
            2: pkt.push_back(8'd1);
            default: pkt.push_back(8'($urandom));
        endcase
        pkt.push_back(8'd0);
        pkt.push_back(8'd0);
        for (i = 12; i < 20; i++) pkt.push_back(8'($urandom));
        // Options: mostly well formed, sometimes a timestamp option.
        i = 20;
        while (i < hl) begin
            if (options_ts && hl - i >= 12 && $urandom_range(1)) begin
                olen = $urandom_range(12, hl - i);
                pkt.push_back(OPT_TIMESTAMP);
            end else if ($urandom_range(3) == 0) begin
                olen = 1;
                pkt.push_back(8'($urandom_range(0, 2)));
            end else begin
                olen = $urandom_range(2, hl - i < 2 ? 2 : hl - i);
                pkt.push_back(8'($urandom));
            end
            if (i + 1 < hl) pkt.push_back(8'(olen));
            for (s = 2; s < olen && i + s < hl; s++) pkt.push_back(8'($urandom));
            i = i + (olen < 2 ? 2 : olen);
        end
        while (pkt.size() > hl && hl >= 20) void'(pkt.pop_back());
        s = 0;
        for (i = 0; i + 1 < hl; i += 2) begin
            s += {pkt[i], pkt[i + 1]};
            s = (s & 16'hffff) + (s >> 16);
        end
        csum = ~16'(s);
        if (!good_sum) csum = csum ^ 16'(1 << $urandom_range(15));
        if (hl >= 20) begin
            pkt[10] = csum[15:8];
            pkt[11] = csum[7:0];
        end
        for (i = 0; i < payload; i++) pkt.push_back(8'($urandom));
    endfunction

    task automatic random_packet();
        logic [7:0] pkt[$];
        int kind, n, i;
        kind = $urandom_range(99);
        if (kind < 75) begin
            build_packet(pkt, $urandom_range(5, 15), $urandom_range(0, 12),
                         $urandom_range(9) != 0, $urandom_range(14) == 0,
                         $urandom_range(14) != 0, 1'b1);
            // Occasionally bend the total length or trim the packet.
            if ($urandom_range(19) == 0) pkt[3] = 8'($urandom);
            if ($urandom_range(19) == 0 && pkt.size() > 20) void'(pkt.pop_back());
        end else if (kind < 85) begin
            n = $urandom_range(1, 19);
            for (i = 0; i < n; i++) pkt.push_back(8'($urandom));
        end else begin
            n = $urandom_range(20, 70);
            for (i = 0; i < n; i++) pkt.push_back(8'($urandom));
            if ($urandom_range(1)) pkt[0] = {4'h4, 4'($urandom)};
            if ($urandom_range(1)) begin
                pkt[6] = 8'($urandom) & 8'h80;
                pkt[7] = 8'd0;
            end
        end
        send_packet(pkt, 1'($urandom));
    endtask

    initial begin
        logic [7:0] pkt[$];
        int i;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        external_checksum_bad = 1'b0;
        cfg_write = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 1'b0;
        idle_cycles = 0;
        no_idle = 1'b0;
        pop_idle_pct = 22;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part under reset settings (external flag, strict).
        build_packet(pkt, 5, 0, 1'b1, 1'b0, 1'b1, 1'b0);
        send_packet(pkt, 1'b0);
        send_packet(pkt, 1'b1);
        // A single-byte packet is the shortest possible.
        pkt = '{8'hff};
        send_packet(pkt, 1'b0);
        build_packet(pkt, 5, 3, 1'b1, 1'b1, 1'b1, 1'b0);
        send_packet(pkt, 1'b0);
        // Header reaches past the end of the packet.
        build_packet(pkt, 15, 0, 1'b1, 1'b0, 1'b1, 1'b1);
        while (pkt.size() > 30) void'(pkt.pop_back());
        send_packet(pkt, 1'b0);
        // IHL below five.
        build_packet(pkt, 5, 0, 1'b1, 1'b0, 1'b1, 1'b0);
        pkt[0] = 8'h43;
        send_packet(pkt, 1'b0);
        // Total length larger than the packet.
        build_packet(pkt, 5, 0, 1'b1, 1'b0, 1'b1, 1'b0);
        pkt[2] = 8'hff;
        pkt[3] = 8'hff;
        send_packet(pkt, 1'b0);
        build_packet(pkt, 5, 0, 1'b1, 1'b0, 1'b0, 1'b0);
        pkt[0] = 8'h65;
        send_packet(pkt, 1'b0);
        // Timestamp option filling the whole option area.
        build_packet(pkt, 8, 2, 1'b1, 1'b0, 1'b1, 1'b0);
        pkt[20] = OPT_TIMESTAMP;
        pkt[21] = 8'd12;
        for (i = 22; i < 32; i++) pkt[i] = 8'(8'hf0 + i);
        send_packet(pkt, 1'b0);
        // Zero-length option and short timestamp option are both bad.
        build_packet(pkt, 6, 0, 1'b1, 1'b0, 1'b1, 1'b0);
        pkt[20] = 8'h07;
        pkt[21] = 8'd0;
        send_packet(pkt, 1'b0);
        build_packet(pkt, 8, 0, 1'b1, 1'b0, 1'b1, 1'b0);
        pkt[20] = OPT_TIMESTAMP;
        pkt[21] = 8'd11;
        send_packet(pkt, 1'b0);
        // Reserved bit with everything else good.
        build_packet(pkt, 5, 1, 1'b1, 1'b0, 1'b1, 1'b0);
        pkt[6] = 8'h80;
        send_packet(pkt, 1'b0);
        drain();

        // Random phases over every setting of the two registers, with the
        // sender pausing for a full drain at each change.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_CHECKSUM_SOURCE, 1'(ph));
            write_reg(REG_STRICT_CHECKS, 1'(ph >> 1));
            no_idle = (ph == 3);
            // One phase lets the receiver stall hard so that full rises.
            pop_idle_pct = (ph == 4) ? 85 : 22;
            for (i = 0; i < ((ph == 3) ? 8 : 4); i++) random_packet();
            drain();
        end
        write_reg(REG_CHECKSUM_SOURCE, 1'b0);
        write_reg(REG_STRICT_CHECKS, 1'b1);
        for (i = 0; i < 8; i++) random_packet();
        drain();
        no_idle = 1'b0;

        if (fail_count == 0 && pending_verdicts == 0)
            $display("tb_ipv4_receive_header_checker_core OK");
        else
            $display("tb_ipv4_receive_header_checker_core NOT OK");
        $finish;
    end

endmodule

// ----- ipv4_receive_header_checker_core.f -----
rtl/ipv4hc_pkg.sv
rtl/ipv4hc_front.sv
rtl/ipv4hc_queue.sv
rtl/ipv4hc_back.sv
rtl/ipv4_receive_header_checker_core.sv
verif/ipv4hc_checker.sv
verif/tb_ipv4_receive_header_checker_core.sv
